/* src/triangle_face_normal_macros.svh */
// ----------------------------------------------------------------------------
// triangle_face_normal_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TFN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("triangle_face_normal: check failed");

// Next-cycle implication, held off during reset.
`define TFN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("triangle_face_normal: check failed");

`endif

/* src/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants and types of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

    localparam int COORD_WIDTH_DEF  = 24;
    localparam int NORMAL_WIDTH_DEF = 32;

    // Normalized magnitude width: top set bit of the largest term lands on bit 30.
    localparam int MAG_BITS = 31;
    // Width of the sum of squares and of the root/divider datapath.
    localparam int SUM_BITS = 64;
    // One root bit per stage.
    localparam int ROOT_STEPS = SUM_BITS / 2;

    // Data riding alongside the root and divide stages.
    typedef struct packed {
        logic [2:0][MAG_BITS-1:0] m;
        logic [2:0]               neg;
        logic                     dgn;
    } t_side;

endpackage

`default_nettype wire

/* src/tfn_channels.sv */
// ----------------------------------------------------------------------------
// tfn_channels
// Valid/ready channels: triangle beats in, normal beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfn_in_if #(
    parameter int CW = tfn_pkg::COORD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by_coord;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;

    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface tfn_out_if #(
    parameter int NW = tfn_pkg::NORMAL_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    logic                 degenerate;

    modport source (output valid, nx, ny, nz, degenerate, input ready);
    modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface

`default_nettype wire

/* src/triangle_face_normal.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle: edges, cross product, normalize.
// ----------------------------------------------------------------------------
// One triangle beat in, one normal beat out, one beat per clock sustained
// while the sink takes them. The pipeline is fully registered; its depth
// is set mostly by the square root (one result bit per stage, 32 stages)
// and the divider (one quotient bit per stage, three lanes). The whole
// pipeline advances together: it moves whenever the output register is
// empty or being taken, so a stalled sink freezes every stage and nothing is
// lost or repeated. Edges B-A and C-A and their cross product are exact;
// the cross product is scaled by a power of two so the largest component
// has its top bit at bit 30 (right shifts truncate), then divided by the
// floored square root of the sum of squares with round half up. Output is
// signed with NORMAL_WIDTH-2 fraction bits. A zero cross product yields a
// zero vector with degenerate set.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal #(
    parameter int COORD_WIDTH  = tfn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_WIDTH = tfn_pkg::NORMAL_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tfn_in_if.sink    i_tri,
    tfn_out_if.source o_nrm
);

    localparam int EW    = COORD_WIDTH + 1;          // edge width
    localparam int PW    = 2 * EW;                   // product width
    localparam int XW    = PW + 1;                   // signed cross width
    localparam int MAGW  = 2 * COORD_WIDTH + 2;      // cross magnitude width
    localparam int MB    = tfn_pkg::MAG_BITS;
    localparam int SHW   = (MAGW > MB) ? MAGW : MB;  // shifter width
    localparam int LZW   = $clog2(SHW + 1);
    localparam int SW    = tfn_pkg::SUM_BITS;
    localparam int RS    = tfn_pkg::ROOT_STEPS;
    localparam int FRAC  = NORMAL_WIDTH - 2;
    localparam int QW    = FRAC + 1;
    localparam int NST   = 7 + RS + 1 + QW + 1;     // total stages

    // Pipeline advance and valid chain.
    logic           en;
    logic [NST-1:0] r_vld;

    assign en          = !r_vld[NST-1] || o_nrm.ready;
    assign i_tri.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_tri.valid};
        end
    end

    // Stage 1: edges.
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1[0] <= EW'(i_tri.bx)       - EW'(i_tri.ax);
            r_e1[1] <= EW'(i_tri.by_coord) - EW'(i_tri.ay);
            r_e1[2] <= EW'(i_tri.bz)       - EW'(i_tri.az);
            r_e2[0] <= EW'(i_tri.cx)       - EW'(i_tri.ax);
            r_e2[1] <= EW'(i_tri.cy)       - EW'(i_tri.ay);
            r_e2[2] <= EW'(i_tri.cz)       - EW'(i_tri.az);
        end
    end

    // Stage 2: six products.
    logic signed [PW-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
        end
    end

    // Stage 3: cross product as sign and magnitude.
    logic signed [XW-1:0] cr [3];
    logic [2:0]           r_cneg;
    logic [MAGW-1:0]      r_cmag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr[i] = XW'(r_p[2*i]) - XW'(r_p[2*i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_cneg[i] <= cr[i][XW-1];
                r_cmag[i] <= cr[i][XW-1] ? MAGW'(-cr[i]) : MAGW'(cr[i]);
            end
        end
    end

    // Stage 4: bit length of the largest magnitude.
    logic [MAGW-1:0] mag_or;
    logic [LZW-1:0]  n_bl;
    logic [LZW-1:0]  r_bl;
    logic [2:0]      r_cneg4;
    logic [MAGW-1:0] r_cmag4 [3];

    always_comb begin
        mag_or = r_cmag[0] | r_cmag[1] | r_cmag[2];
        n_bl   = '0;
        for (int b = 0; b < MAGW; b++) begin
            if (mag_or[b]) begin
                n_bl = LZW'(b + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bl    <= n_bl;
            r_cneg4 <= r_cneg;
            r_cmag4 <= r_cmag;
        end
    end

    // Stage 5: common normalizing shift.
    tfn_pkg::t_side n_s5;
    tfn_pkg::t_side r_s5;
    logic [SHW-1:0] sh [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_bl > LZW'(MB)) begin
                sh[i] = SHW'(r_cmag4[i]) >> (r_bl - LZW'(MB));
            end else begin
                sh[i] = SHW'(r_cmag4[i]) << (LZW'(MB) - r_bl);
            end
            n_s5.m[i] = sh[i][MB-1:0];
        end
        n_s5.neg = r_cneg4;
        n_s5.dgn = (r_bl == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5 <= n_s5;
        end
    end

    // Stage 6: squares.
    logic [2*MB-1:0] r_sq [3];
    tfn_pkg::t_side  r_s6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_s5.m[i] * r_s5.m[i];
            end
            r_s6 <= r_s5;
        end
    end

    // Stage 7: sum of squares.
    logic [SW-1:0]  r_sum;
    tfn_pkg::t_side r_s7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_s7  <= r_s6;
        end
    end

    // Square root: one result bit per stage.
    logic [SW-1:0]  r_rt_x    [RS];
    logic [SW-1:0]  r_rt_res  [RS];
    tfn_pkg::t_side r_rt_side [RS];

    for (genvar j = 0; j < RS; j++) begin : g_root
        logic [SW-1:0]  x_in;
        logic [SW-1:0]  res_in;
        logic [SW-1:0]  trial;
        tfn_pkg::t_side side_in;
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * j);

        if (j == 0) begin : g_first
            assign x_in    = r_sum;
            assign res_in  = '0;
            assign side_in = r_s7;
        end else begin : g_next
            assign x_in    = r_rt_x[j-1];
            assign res_in  = r_rt_res[j-1];
            assign side_in = r_rt_side[j-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (x_in >= trial) begin
                    r_rt_x[j]   <= x_in - trial;
                    r_rt_res[j] <= (res_in >> 1) + BIT;
                end else begin
                    r_rt_x[j]   <= x_in;
                    r_rt_res[j] <= res_in >> 1;
                end
                r_rt_side[j] <= side_in;
            end
        end
    end

    // Divider setup: numerator with half the divisor added for rounding.
    logic [SW-1:0]  r_dp_num [3];
    logic [SW-1:0]  r_dp_len;
    tfn_pkg::t_side r_dp_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_dp_num[i] <= (SW'(r_rt_side[RS-1].m[i]) << FRAC) + (r_rt_res[RS-1] >> 1);
            end
            r_dp_len  <= r_rt_res[RS-1];
            r_dp_side <= r_rt_side[RS-1];
        end
    end

    // Restoring divider: one quotient bit per stage, three lanes.
    logic [SW-1:0]  r_dv_rem  [QW][3];
    logic [QW-1:0]  r_dv_q    [QW][3];
    logic [SW-1:0]  r_dv_len  [QW];
    tfn_pkg::t_side r_dv_side [QW];

    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int K = QW - 1 - s;
        logic [SW-1:0]  rem_in [3];
        logic [QW-1:0]  q_in   [3];
        logic [SW-1:0]  len_in;
        logic [SW-1:0]  dsh;
        tfn_pkg::t_side side_in;

        if (s == 0) begin : g_first
            assign rem_in  = r_dp_num;
            assign q_in    = '{default: '0};
            assign len_in  = r_dp_len;
            assign side_in = r_dp_side;
        end else begin : g_next
            assign rem_in  = r_dv_rem[s-1];
            assign q_in    = r_dv_q[s-1];
            assign len_in  = r_dv_len[s-1];
            assign side_in = r_dv_side[s-1];
        end

        assign dsh = len_in << K;

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_in[i] >= dsh) begin
                        r_dv_rem[s][i] <= rem_in[i] - dsh;
                        r_dv_q[s][i]   <= q_in[i] | (QW'(1) << K);
                    end else begin
                        r_dv_rem[s][i] <= rem_in[i];
                        r_dv_q[s][i]   <= q_in[i];
                    end
                end
                r_dv_len[s]  <= len_in;
                r_dv_side[s] <= side_in;
            end
        end
    end

    // Output register: sign, degenerate override.
    logic signed [NORMAL_WIDTH-1:0] r_n [3];
    logic                           r_dgn;
    logic signed [NORMAL_WIDTH-1:0] qs  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qs[i] = NORMAL_WIDTH'(r_dv_q[QW-1][i]);
            if (r_dv_side[QW-1].dgn) begin
                qs[i] = '0;
            end else if (r_dv_side[QW-1].neg[i]) begin
                qs[i] = -qs[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n   <= qs;
            r_dgn <= r_dv_side[QW-1].dgn;
        end
    end

    assign o_nrm.valid      = r_vld[NST-1];
    assign o_nrm.nx         = r_n[0];
    assign o_nrm.ny         = r_n[1];
    assign o_nrm.nz         = r_n[2];
    assign o_nrm.degenerate = r_dgn;

endmodule

`default_nettype wire

/* src/tfn_checker.sv */
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks on the normal output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_face_normal_macros.svh"

module tfn_checker #(
    parameter int NW = tfn_pkg::NORMAL_WIDTH_DEF
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_valid,
    input wire logic          i_ready,
    input wire logic [NW-1:0] i_nx,
    input wire logic [NW-1:0] i_ny,
    input wire logic [NW-1:0] i_nz,
    input wire logic          i_dgn
);

    // Degenerate beats carry a zero vector.
    `TFN_ASSERT_NOW(a_dgn_zero, i_valid && i_dgn, i_nx == '0 && i_ny == '0 && i_nz == '0)

    // A real triangle never normalizes to all zeros.
    `TFN_ASSERT_NOW(a_live_nonzero, i_valid && !i_dgn, i_nx != '0 || i_ny != '0 || i_nz != '0)

    // A stalled beat stays offered.
    `TFN_ASSERT_NEXT(a_hold_valid, i_valid && !i_ready, i_valid)

    // ...and unchanged.
    `TFN_ASSERT_NEXT(a_hold_data, i_valid && !i_ready, $stable(i_nx) && $stable(i_ny) && $stable(i_nz) && $stable(i_dgn))

endmodule

bind triangle_face_normal tfn_checker #(
    .NW (NORMAL_WIDTH)
) u_tfn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_nrm.valid),
    .i_ready (o_nrm.ready),
    .i_nx    (o_nrm.nx),
    .i_ny    (o_nrm.ny),
    .i_nz    (o_nrm.nz),
    .i_dgn   (o_nrm.degenerate)
);

`default_nettype wire
